FILE: hw/rtl/va_pkg.sv
// Shared constants, types and helper functions for the vector angle pipeline.
package va_pkg;

    localparam int COMP_W_DEF   = 16;
    localparam int NORM_W       = 30;   // normalized magnitude width
    localparam int SQ_W         = 60;
    localparam int SUM_W        = 62;
    localparam int ISQ_W        = 63;   // root extractor working width
    localparam int ISQ_STEPS    = 31;
    localparam int ROOT_W       = 31;
    localparam int CORDIC_STEPS = 31;
    localparam int XY_W         = 35;
    localparam int Z_W          = 34;
    localparam int T_W          = 36;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_MAX    = 51472;
    localparam int ATAN_LEN     = 11;
    localparam logic [T_W-1:0] PI_Q30     = T_W'(64'd3373259426);
    localparam logic [T_W-1:0] ROUND_HALF = T_W'(32768);

    // Side data that travels with each request through the pipeline
    typedef struct packed {
        logic              dpos;    // dot product strictly positive
        logic              deg;     // one vector is zero
        logic [NORM_W-1:0] xn;      // normalized |dot|
    } t_tag;

    // Angle increment of CORDIC step i, Q30
    function automatic logic [Z_W-1:0] atan_step(input int i);
        logic [Z_W-1:0] v;
        case (i)
            0:       v = Z_W'(843314857);
            1:       v = Z_W'(497837829);
            2:       v = Z_W'(263043837);
            3:       v = Z_W'(133525159);
            4:       v = Z_W'(67021687);
            5:       v = Z_W'(33543516);
            6:       v = Z_W'(16775851);
            7:       v = Z_W'(8388437);
            8:       v = Z_W'(4194283);
            9:       v = Z_W'(2097149);
            10:      v = Z_W'(1048576);
            default: v = Z_W'(64'd1 << (30 - i));
        endcase
        return v;
    endfunction

    // Arithmetic right shift that truncates toward zero
    function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                      input int k);
        logic [XY_W-1:0] a;
        a = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
        a = a >> k;
        return v[XY_W-1] ? signed'(-a) : signed'(a);
    endfunction

endpackage

FILE: hw/rtl/va_in_if.sv
// Request channel: two 3D vectors with valid/ready.
interface va_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] p_x;
    logic signed [W-1:0] p_y;
    logic signed [W-1:0] p_z;
    logic signed [W-1:0] q_x;
    logic signed [W-1:0] q_y;
    logic signed [W-1:0] q_z;

    modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, input ready);
    modport sink   (input valid, p_x, p_y, p_z, q_x, q_y, q_z, output ready);
endinterface

FILE: hw/rtl/va_out_if.sv
// Result channel: angle and degenerate flag with valid/ready.
interface va_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle;
    logic        degenerate;

    modport source (output valid, angle, degenerate, input ready);
    modport sink   (input valid, angle, degenerate, output ready);
endinterface

FILE: hw/rtl/va_front.sv
// Front end: products, cross/dot magnitudes, shared normalization, sum of squares.
module va_front #(
    parameter int COMP_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [COMP_W-1:0]   i_px,
    input  logic signed [COMP_W-1:0]   i_py,
    input  logic signed [COMP_W-1:0]   i_pz,
    input  logic signed [COMP_W-1:0]   i_qx,
    input  logic signed [COMP_W-1:0]   i_qy,
    input  logic signed [COMP_W-1:0]   i_qz,
    output logic                       o_valid,
    output logic [va_pkg::SUM_W-1:0]   o_sum,
    output va_pkg::t_tag               o_tag
);
    import va_pkg::*;

    localparam int PW   = 2 * COMP_W;
    localparam int MW   = 2 * COMP_W + 2;
    localparam int LW   = MW + NORM_W;
    localparam int LENW = $clog2(MW + 1);

    logic [5:0] r_v;

    logic signed [PW-1:0] r_pr [9];
    logic                 r_deg1;

    logic [MW-1:0]        r_m2 [4];
    logic                 r_deg2, r_dpos2;

    logic [MW-1:0]        r_m3 [4];
    logic [LENW-1:0]      r_len3;
    logic                 r_deg3, r_dpos3;

    logic [NORM_W-1:0]    r_n4 [4];
    logic                 r_deg4, r_dpos4;

    logic [SQ_W-1:0]      r_sq5 [3];
    logic [NORM_W-1:0]    r_xn5;
    logic                 r_deg5, r_dpos5;

    logic [SUM_W-1:0]     r_sum6;
    t_tag                 r_tag6;

    logic signed [MW-1:0] cr [3];
    logic signed [MW-1:0] dot;
    logic [MW-1:0]        n_m2 [4];
    logic [MW-1:0]        or_v;
    logic [LENW-1:0]      n_len;
    logic [LW-1:0]        sh [4];

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // stage 2 logic: exact cross and dot products as magnitudes
    always_comb begin
        cr[0] = MW'(r_pr[0]) - MW'(r_pr[1]);
        cr[1] = MW'(r_pr[2]) - MW'(r_pr[3]);
        cr[2] = MW'(r_pr[4]) - MW'(r_pr[5]);
        dot   = MW'(r_pr[6]) + MW'(r_pr[7]) + MW'(r_pr[8]);
        for (int k = 0; k < 3; k++) begin
            n_m2[k] = cr[k][MW-1] ? MW'(-cr[k]) : MW'(cr[k]);
        end
        n_m2[3] = dot[MW-1] ? MW'(-dot) : MW'(dot);
    end

    // stage 3 logic: bit length of the largest magnitude
    always_comb begin
        or_v  = r_m2[0] | r_m2[1] | r_m2[2] | r_m2[3];
        n_len = '0;
        for (int b = 0; b < MW; b++) begin
            if (or_v[b]) n_len = LENW'(b + 1);
        end
    end

    // stage 4 logic: common shift to a 30-bit top
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_len3 > LENW'(NORM_W)) begin
                sh[k] = LW'(r_m3[k]) >> (r_len3 - LENW'(NORM_W));
            end else begin
                sh[k] = LW'(r_m3[k]) << (LENW'(NORM_W) - r_len3);
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr[0] <= PW'(i_py * i_qz);
            r_pr[1] <= PW'(i_pz * i_qy);
            r_pr[2] <= PW'(i_pz * i_qx);
            r_pr[3] <= PW'(i_px * i_qz);
            r_pr[4] <= PW'(i_px * i_qy);
            r_pr[5] <= PW'(i_py * i_qx);
            r_pr[6] <= PW'(i_px * i_qx);
            r_pr[7] <= PW'(i_py * i_qy);
            r_pr[8] <= PW'(i_pz * i_qz);
            r_deg1  <= (i_px == '0 && i_py == '0 && i_pz == '0) ||
                       (i_qx == '0 && i_qy == '0 && i_qz == '0);

            r_m2    <= n_m2;
            r_deg2  <= r_deg1;
            r_dpos2 <= !dot[MW-1] && (dot != '0);

            r_m3    <= r_m2;
            r_len3  <= n_len;
            r_deg3  <= r_deg2;
            r_dpos3 <= r_dpos2;

            for (int k = 0; k < 4; k++) r_n4[k] <= sh[k][NORM_W-1:0];
            r_deg4  <= r_deg3;
            r_dpos4 <= r_dpos3;

            for (int k = 0; k < 3; k++) r_sq5[k] <= SQ_W'(r_n4[k]) * SQ_W'(r_n4[k]);
            r_xn5   <= r_n4[3];
            r_deg5  <= r_deg4;
            r_dpos5 <= r_dpos4;

            r_sum6      <= SUM_W'(r_sq5[0]) + SUM_W'(r_sq5[1]) + SUM_W'(r_sq5[2]);
            r_tag6.dpos <= r_dpos5;
            r_tag6.deg  <= r_deg5;
            r_tag6.xn   <= r_xn5;
        end
    end

    assign o_valid = r_v[5];
    assign o_sum   = r_sum6;
    assign o_tag   = r_tag6;

endmodule

FILE: hw/rtl/va_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module va_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [va_pkg::SUM_W-1:0]  i_sum,
    input  va_pkg::t_tag              i_tag,
    output logic                      o_valid,
    output logic [va_pkg::ROOT_W-1:0] o_root,
    output va_pkg::t_tag              o_tag
);
    import va_pkg::*;

    logic [ISQ_STEPS-1:0] r_v;
    logic [ISQ_W-1:0]     r_rem [ISQ_STEPS];
    logic [ISQ_W-1:0]     r_res [ISQ_STEPS];
    t_tag                 r_tag [ISQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ISQ_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [ISQ_W-1:0] rem_in, res_in, trial;
        t_tag             tag_in;

        if (k == 0) begin : g_first
            assign rem_in = ISQ_W'(i_sum);
            assign res_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign res_in = r_res[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign trial = res_in + BIT;

        // one compare-subtract per stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_valid = r_v[ISQ_STEPS-1];
    assign o_root  = r_res[ISQ_STEPS-1][ROOT_W-1:0];
    assign o_tag   = r_tag[ISQ_STEPS-1];

endmodule

FILE: hw/rtl/va_cordic.sv
// Pipelined CORDIC vectoring (atan2) followed by quadrant fix and rounding.
module va_cordic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [va_pkg::ROOT_W-1:0]  i_root,
    input  va_pkg::t_tag               i_tag,
    output logic                       o_valid,
    output logic [va_pkg::ANGLE_W-1:0] o_angle,
    output logic                       o_deg
);
    import va_pkg::*;

    logic [CORDIC_STEPS:0]   r_v;
    logic signed [XY_W-1:0]  r_x [CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_y [CORDIC_STEPS];
    logic signed [Z_W-1:0]   r_z [CORDIC_STEPS];
    t_tag                    r_tag [CORDIC_STEPS];
    logic [ANGLE_W-1:0]      r_angle;
    logic                    r_deg;

    logic signed [T_W-1:0]   t;
    logic [T_W-1:0]          t_c;
    logic [T_W-1:0]          a;
    logic [ANGLE_W-1:0]      n_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CORDIC_STEPS-1:0], i_valid};
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] STEP = signed'(atan_step(i));
        logic signed [XY_W-1:0] x_in, y_in, dx, dy;
        logic signed [Z_W-1:0]  z_in;
        t_tag                   tag_in;

        if (i == 0) begin : g_first
            assign x_in   = signed'(XY_W'(i_tag.xn));
            assign y_in   = signed'(XY_W'(i_root));
            assign z_in   = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign x_in   = r_x[i-1];
            assign y_in   = r_y[i-1];
            assign z_in   = r_z[i-1];
            assign tag_in = r_tag[i-1];
        end

        assign dx = shr_tz(y_in, i);
        assign dy = shr_tz(x_in, i);

        // rotate toward y = 0, y >= 0 counts as positive
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[XY_W-1]) begin
                    r_x[i] <= x_in + dx;
                    r_y[i] <= y_in - dy;
                    r_z[i] <= z_in + STEP;
                end else begin
                    r_x[i] <= x_in - dx;
                    r_y[i] <= y_in + dy;
                    r_z[i] <= z_in - STEP;
                end
                r_tag[i] <= tag_in;
            end
        end
    end

    // quadrant fix, clamp and round to Q2.14
    always_comb begin
        if (r_tag[CORDIC_STEPS-1].dpos) begin
            t = T_W'(r_z[CORDIC_STEPS-1]);
        end else begin
            t = signed'(PI_Q30) - T_W'(r_z[CORDIC_STEPS-1]);
        end
        t_c = t[T_W-1] ? '0 : T_W'(t);
        a   = (t_c + ROUND_HALF) >> 16;
        if (a > T_W'(ANGLE_MAX)) begin
            n_angle = ANGLE_W'(ANGLE_MAX);
        end else begin
            n_angle = a[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_tag[CORDIC_STEPS-1].deg ? '0 : n_angle;
            r_deg   <= r_tag[CORDIC_STEPS-1].deg;
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_angle = r_angle;
    assign o_deg   = r_deg;

endmodule

FILE: hw/rtl/vector3_angle_arcsin.sv
// Top level: angle between two 3D vectors, Q2.14 radians.
//
//  channel | dir | payload                          | handshake
//  i_req   | in  | p_x p_y p_z q_x q_y q_z (signed) | valid/ready
//  o_res   | out | angle[15:0], degenerate         | valid/ready
//
// One request enters per cycle unless stalled; the path has 6 front stages
// (multiply, cross/dot, bit length, shift, square, sum), 31 square-root
// stages, 31 CORDIC stages and the output register, which also rounds.
// Reset clears only the valid bits. When the output holds a result that is
// not taken, the whole pipeline stalls and i_req.ready drops; no data is lost.
module vector3_angle_arcsin #(
    parameter int COMPONENT_WIDTH = va_pkg::COMP_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    va_in_if.sink     i_req,
    va_out_if.source  o_res
);
    import va_pkg::*;

    logic               en;
    logic               fe_valid, sq_valid, co_valid;
    logic [SUM_W-1:0]   fe_sum;
    t_tag               fe_tag, sq_tag;
    logic [ROOT_W-1:0]  sq_root;
    logic [ANGLE_W-1:0] co_angle;
    logic               co_deg;

    // global advance: output empty or being taken
    assign en          = !co_valid || o_res.ready;
    assign i_req.ready = en;

    va_front #(.COMP_W(COMPONENT_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_px    (i_req.p_x),
        .i_py    (i_req.p_y),
        .i_pz    (i_req.p_z),
        .i_qx    (i_req.q_x),
        .i_qy    (i_req.q_y),
        .i_qz    (i_req.q_z),
        .o_valid (fe_valid),
        .o_sum   (fe_sum),
        .o_tag   (fe_tag)
    );

    va_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fe_valid),
        .i_sum   (fe_sum),
        .i_tag   (fe_tag),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    va_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_tag   (sq_tag),
        .o_valid (co_valid),
        .o_angle (co_angle),
        .o_deg   (co_deg)
    );

    assign o_res.valid      = co_valid;
    assign o_res.angle      = co_angle;
    assign o_res.degenerate = co_deg;

    // checks
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.degenerate |-> o_res.angle == '0)
        else $error("degenerate result with nonzero angle");

    a_angle_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.angle <= ANGLE_W'(ANGLE_MAX))
        else $error("angle above pi");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_res.valid || o_res.ready))
        else $error("input ready does not follow output stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule
